@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the formatter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, b)
`define ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

@@ rtl/core/itf_pkg.sv @@
// Package of the integer text formatter: types, codes and constants.
`default_nettype none
package itf_pkg;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int TEXT_BUFFER_DEF = 32;

    typedef enum logic [2:0] {
        OP_CHAR = 3'd0, OP_SDEC = 3'd1, OP_UDEC = 3'd2, OP_HEX = 3'd3, OP_PTR = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CONV, ST_PREFIX, ST_EMIT
    } state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;
        logic conv_step;
        logic prefix;
        logic emit;
    } cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic conv_done;
        logic emit_done;
        logic drop;
    } sts_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
endpackage
`default_nettype wire

@@ rtl/core/itf_ctrl.sv @@
// Controller state machine of the integer text formatter.
`default_nettype none
module itf_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_req,
    input  wire logic          out_free,
    input  wire itf_pkg::sts_t sts,
    output itf_pkg::cmd_t      cmd,
    output logic               busy
);
    import itf_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_req) begin
                    cmd.load = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (sts.drop) begin
                    state_next = ST_IDLE;
                end else if (sts.conv_done) begin
                    state_next = ST_PREFIX;
                end else begin
                    cmd.conv_step = 1'b1;
                end
            end
            ST_PREFIX: begin
                cmd.prefix = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.emit_done) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    cmd.emit = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
endmodule
`default_nettype wire

@@ rtl/core/itf_dp.sv @@
// Datapath: digit extraction into a text buffer, then character emission.
`default_nettype none
module itf_dp #(
    parameter int MAX_WIDTH   = itf_pkg::MAX_WIDTH_DEF,
    parameter int TEXT_BUFFER = itf_pkg::TEXT_BUFFER_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire itf_pkg::cmd_t cmd,
    input  wire logic [2:0]    op,
    input  wire logic [63:0]   value,
    input  wire logic          arg_size,
    input  wire logic          alternate,
    input  wire logic          zero_pad,
    input  wire logic          left_justify,
    input  wire logic          group_digits,
    input  wire logic [6:0]    min_width,
    input  wire logic          limit_on,
    input  wire logic [6:0]    max_chars,
    output itf_pkg::sts_t      sts,
    output logic [7:0]         char_out,
    output logic               last
);
    import itf_pkg::*;

    localparam int PW = $clog2(TEXT_BUFFER + 1);
    // Phase of the divider at which quotient and remainder are ready.
    localparam logic [2:0] DIV_LAST = 3'd6;

    logic [7:0]    buf_reg [TEXT_BUFFER];
    logic [PW-1:0] len_reg;
    logic [63:0]   val_reg;
    logic [4:0]    cnt_reg;
    logic          neg_reg, hex_reg, grp_reg, alt_reg, zf_reg, left_reg, limon_reg;
    logic [6:0]    width_reg, lim_reg, k_reg;
    logic          sep_pend_reg;
    logic          drop_reg;

    logic [63:0] v_ext, q10;
    logic [3:0]  digit;
    logic [7:0]  dch, ch_new;
    logic        push;
    logic [6:0]  wsat;
    logic [6:0]  len7;
    logic [PW-1:0] addr;

    // Division by ten in phases: a shift-add estimate of the quotient,
    // then the remainder, then a correction by one where the remainder reaches ten.
    logic [2:0]  div_ph_reg;
    logic [63:0] q_reg, r_full, q_dec;
    logic [4:0]  r_reg;
    logic        fix, div_run;

    assign r_full = val_reg - ((q_reg << 3) + (q_reg << 1));
    assign fix = (r_reg > 5'd9);
    assign q_dec = q_reg + {63'd0, fix};
    assign div_run = cmd.conv_step && !hex_reg && !sep_pend_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            div_ph_reg <= '0;
        end else if (div_run) begin
            unique case (div_ph_reg)
                3'd0: q_reg <= (val_reg >> 1) + (val_reg >> 2);
                3'd1: q_reg <= q_reg + (q_reg >> 4);
                3'd2: q_reg <= q_reg + (q_reg >> 8);
                3'd3: q_reg <= q_reg + (q_reg >> 16);
                3'd4: q_reg <= (q_reg + (q_reg >> 32)) >> 3;
                3'd5: r_reg <= r_full[4:0];
                default: ;
            endcase
            div_ph_reg <= (div_ph_reg == DIV_LAST) ? 3'd0 : div_ph_reg + 3'd1;
        end
    end

    assign q10 = hex_reg ? (val_reg >> 4) : q_dec;
    assign digit = hex_reg ? val_reg[3:0] : (fix ? 4'(r_reg - 5'd10) : r_reg[3:0]);
    assign dch = (digit > 4'd9) ? (CH_A + {4'd0, digit} - 8'd10) : (CH_ZERO + {4'd0, digit});

    assign v_ext = (op == OP_PTR || arg_size) ? value : {{32{value[31]}}, value[31:0]};
    assign wsat = (min_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : min_width;
    assign len7 = 7'(len_reg);

    // A separator goes in before the next digit when one is pending.
    assign ch_new = sep_pend_reg ? (hex_reg ? CH_APOS : CH_COMMA) : dch;
    assign push = cmd.conv_step && (sep_pend_reg || hex_reg || div_ph_reg == DIV_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drop_reg <= 1'b0;
        end else begin
            drop_reg <= cmd.load && (op > 3'(OP_PTR));
        end
    end

    // Load, conversion steps and prefix characters.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hex_reg   <= (op == OP_HEX) || (op == OP_PTR);
            grp_reg   <= group_digits || (op == OP_PTR);
            alt_reg   <= alternate || (op == OP_PTR);
            zf_reg    <= zero_pad || (op == OP_PTR);
            left_reg  <= left_justify;
            limon_reg <= limit_on;
            lim_reg   <= max_chars;
            width_reg <= wsat;
            cnt_reg   <= '0;
            sep_pend_reg <= 1'b0;
            neg_reg   <= (op == OP_SDEC) && v_ext[63];
            if (op == OP_CHAR) begin
                buf_reg[0] <= v_ext[7:0];
                len_reg <= PW'(1);
                val_reg <= '0;
            end else if (v_ext == 64'd0) begin
                buf_reg[0] <= CH_ZERO;
                len_reg <= PW'(1);
                val_reg <= '0;
            end else begin
                len_reg <= '0;
                val_reg <= ((op == OP_SDEC) && v_ext[63]) ? (64'd0 - v_ext) : v_ext;
            end
        end else if (push) begin
            for (int i = TEXT_BUFFER - 1; i > 0; i--) begin
                buf_reg[i] <= buf_reg[i-1];
            end
            buf_reg[0] <= ch_new;
            len_reg <= len_reg + PW'(1);
            if (sep_pend_reg) begin
                sep_pend_reg <= 1'b0;
            end else begin
                val_reg <= q10;
                if (grp_reg && q10 != 64'd0 &&
                    (hex_reg ? (cnt_reg[2:0] == 3'd7) : (cnt_reg == 5'd2))) begin
                    sep_pend_reg <= 1'b1;
                end
                cnt_reg <= (!hex_reg && cnt_reg == 5'd2) ? 5'd0 : cnt_reg + 5'd1;
            end
        end else if (cmd.prefix) begin
            if (neg_reg && !hex_reg) begin
                for (int i = TEXT_BUFFER - 1; i > 0; i--) begin
                    buf_reg[i] <= buf_reg[i-1];
                end
                buf_reg[0] <= CH_MINUS;
                len_reg <= len_reg + PW'(1);
            end else if (alt_reg && hex_reg) begin
                for (int i = TEXT_BUFFER - 1; i > 1; i--) begin
                    buf_reg[i] <= buf_reg[i-2];
                end
                buf_reg[1] <= CH_X;
                buf_reg[0] <= CH_ZERO;
                len_reg <= len_reg + PW'(2);
            end
        end
    end

    // Emission bookkeeping: pad count and total once the prefix has settled.
    logic [6:0] padc, totc;
    always_comb begin
        if (limon_reg && len7 > lim_reg) begin
            padc = '0;
            totc = lim_reg;
        end else begin
            padc = (len7 >= width_reg) ? 7'd0 : width_reg - len7;
            totc = len7 + padc;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prefix || cmd.load) begin
            k_reg <= '0;
        end else if (cmd.emit) begin
            k_reg <= k_reg + 7'd1;
        end
    end

    // Character selection for the current position; the first character sits at index 0.
    logic [6:0] ti;
    logic       lead_pad, in_text;
    always_comb begin
        lead_pad = (padc != 0) && (zf_reg || !left_reg) && (k_reg < padc);
        ti = lead_pad ? 7'd0 :
             ((padc != 0) && (zf_reg || !left_reg)) ? k_reg - padc : k_reg;
        in_text = !lead_pad && (ti < len7);
        addr = PW'(ti);
        if (lead_pad) begin
            char_out = zf_reg ? CH_ZERO : CH_SPACE;
        end else if (in_text) begin
            char_out = buf_reg[addr[$clog2(TEXT_BUFFER)-1:0]];
        end else begin
            char_out = CH_SPACE;
        end
        last = (k_reg == totc - 7'd1);
    end

    assign sts.conv_done = (val_reg == 64'd0) && !sep_pend_reg;
    assign sts.drop = drop_reg;
    assign sts.emit_done = (k_reg == totc);
endmodule
`default_nettype wire

@@ rtl/core/integer_text_formatter_unit.sv @@
// Top level of the integer text formatter.
// Flow: an accepted request is loaded, then converted step by step; a decimal digit
// runs through the divider phases, a hexadecimal digit or a separator is pushed at once.
// Then the prefix. Throughput: one request at a time, after conversion one character
// per cycle (at most 64) as the receiver takes them, then back to idle.
// Reset: aresetn synchronous active low returns the controller to idle.
`default_nettype none
module integer_text_formatter_unit #(
    parameter int MAX_WIDTH   = itf_pkg::MAX_WIDTH_DEF,
    parameter int TEXT_BUFFER = itf_pkg::TEXT_BUFFER_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // op[2:0], value[66:3], arg_size[67], alternate[68], zero_pad[69],
    // left_justify[70], group_digits[71], min_width[78:72], limit_on[79],
    // max_chars[86:80], zeros up to 87
    input  wire logic [87:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // char_out[7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import itf_pkg::*;
    `include "assert_macros.svh"

    cmd_t cmd;
    sts_t sts;
    logic busy, accept;
    logic [7:0]  ch;
    logic        lst;
    logic        out_v_reg;
    logic [7:0]  out_d_reg;
    logic        out_l_reg;

    assign s_tready = !busy;
    assign accept = s_tvalid && s_tready;

    itf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_req(accept),
        .out_free(!out_v_reg || m_tready), .sts(sts), .cmd(cmd), .busy(busy)
    );

    itf_dp #(.MAX_WIDTH(MAX_WIDTH), .TEXT_BUFFER(TEXT_BUFFER)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd),
        .op(s_tdata[2:0]), .value(s_tdata[66:3]), .arg_size(s_tdata[67]),
        .alternate(s_tdata[68]), .zero_pad(s_tdata[69]), .left_justify(s_tdata[70]),
        .group_digits(s_tdata[71]), .min_width(s_tdata[78:72]),
        .limit_on(s_tdata[79]), .max_chars(s_tdata[86:80]),
        .sts(sts), .char_out(ch), .last(lst)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_v_reg <= 1'b1;
        end else if (m_tready) begin
            out_v_reg <= 1'b0;
        end
    end
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_d_reg <= ch;
            out_l_reg <= lst;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;
    assign m_tlast  = out_l_reg;

    `ASSERT_IMPLIES(a_no_accept_busy, aclk, aresetn, busy, !accept)
    `ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_tvalid)
    `ASSERT_IMPLIES(a_one_cmd, aclk, aresetn, 1'b1, $onehot0(cmd))
endmodule
`default_nettype wire
